// File: rtl/ilp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the integer literal parser.
// No dependencies; every other file of the block refers to this package.
package ilp_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CharWidth  = 8;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_OCT = 2'd2,
    RX_BIN = 2'd3
  } radix_t;

  typedef struct packed {
    phase_t                  phase;
    logic                    negative;
    radix_t                  radix_sel;
    logic [ValueWidth-1:0]   magnitude;
    logic                    seen_digit;
  } state_t;

  typedef struct packed {
    logic                         valid_res;
    logic signed [ValueWidth-1:0] value;
  } result_t;

  localparam state_t StateReset = '{
    phase:      PH_START,
    negative:   1'b0,
    radix_sel:  RX_DEC,
    magnitude:  '0,
    seen_digit: 1'b0
  };

endpackage

// File: rtl/ilp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the integer literal parser.
// Depends on ilp_pkg for the payload widths.
interface ilp_in_if;
  logic                             valid;
  logic                             ready;
  logic [ilp_pkg::CharWidth-1:0]    character;
  logic                             last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface ilp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  valid_res;
  logic signed [ilp_pkg::ValueWidth-1:0] value;

  modport source (output valid, output valid_res, output value, input ready);
  modport sink   (input valid, input valid_res, input value, output ready);
endinterface

// File: rtl/ilp_step.sv
`timescale 1ns / 1ps
// Combinational next-state logic of the parser: one character in, new state out,
// plus the result for the last character of a token. Depends on ilp_pkg.
module ilp_step (
  input  ilp_pkg::state_t                 state_cur,
  input  logic [ilp_pkg::CharWidth-1:0]   char_in,
  input  logic                            last_in,
  output ilp_pkg::state_t                 state_nxt,
  output ilp_pkg::result_t                result
);

  localparam int unsigned VW = ilp_pkg::ValueWidth;
  localparam int unsigned PW = VW + 4;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChUpB   = 8'h42;
  localparam logic [7:0] ChLowO  = 8'h6F;
  localparam logic [7:0] ChUpO   = 8'h4F;

  logic            dig_ok;
  logic [3:0]      dig_val;
  logic [7:0]      dig_off;
  logic [PW-1:0]   mag_ext;
  logic [PW-1:0]   product;
  logic [PW-1:0]   sum;
  logic [PW-1:0]   limit;
  logic            fits;
  ilp_pkg::state_t take_st;
  ilp_pkg::state_t step_st;

  // Digit decode in the current radix.
  always_comb begin
    dig_ok  = 1'b0;
    dig_off = '0;
    if (char_in inside {[ChZero:ChNine]}) begin
      dig_ok  = 1'b1;
      dig_off = char_in - ChZero;
    end else if (state_cur.radix_sel == ilp_pkg::RX_HEX &&
                 char_in inside {[ChLowA:ChLowF]}) begin
      dig_ok  = 1'b1;
      dig_off = char_in - ChLowA + 8'd10;
    end else if (state_cur.radix_sel == ilp_pkg::RX_HEX &&
                 char_in inside {[ChUpA:ChUpF]}) begin
      dig_ok  = 1'b1;
      dig_off = char_in - ChUpA + 8'd10;
    end
    dig_val = dig_off[3:0];
    case (state_cur.radix_sel)
      ilp_pkg::RX_OCT: if (dig_off > 8'd7) dig_ok = 1'b0;
      ilp_pkg::RX_BIN: if (dig_off > 8'd1) dig_ok = 1'b0;
      ilp_pkg::RX_DEC: if (dig_off > 8'd9) dig_ok = 1'b0;
      default: ;
    endcase
  end

  // Magnitude times radix plus digit, exact in a few extra bits, checked
  // against the signed limit for the sign of the token.
  always_comb begin
    mag_ext = {4'b0, state_cur.magnitude};
    case (state_cur.radix_sel)
      ilp_pkg::RX_HEX: product = mag_ext << 4;
      ilp_pkg::RX_OCT: product = mag_ext << 3;
      ilp_pkg::RX_BIN: product = mag_ext << 1;
      default:         product = (mag_ext << 3) + (mag_ext << 1);
    endcase
    sum   = product + {{(PW-4){1'b0}}, dig_val};
    limit = {{(PW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};
    if (!state_cur.negative) begin
      limit = limit - {{(PW-1){1'b0}}, 1'b1};
    end
    fits = (sum <= limit);
  end

  always_comb begin
    take_st = state_cur;
    if (!dig_ok) begin
      take_st.phase = ilp_pkg::PH_ERROR;
    end else begin
      take_st.seen_digit = 1'b1;
      if (!fits) begin
        take_st.phase = ilp_pkg::PH_ERROR;
      end else begin
        take_st.magnitude = sum[VW-1:0];
        take_st.phase     = ilp_pkg::PH_DIGITS;
      end
    end
  end

  always_comb begin
    step_st = state_cur;
    case (state_cur.phase)
      ilp_pkg::PH_START, ilp_pkg::PH_SIGN: begin
        if (state_cur.phase == ilp_pkg::PH_START &&
            (char_in == ChPlus || char_in == ChMinus)) begin
          step_st.negative = (char_in == ChMinus);
          step_st.phase    = ilp_pkg::PH_SIGN;
        end else if (char_in == ChZero && !last_in) begin
          step_st.phase      = ilp_pkg::PH_ZERO;
          step_st.seen_digit = 1'b1;
          step_st.magnitude  = '0;
        end else begin
          step_st = take_st;
        end
      end
      ilp_pkg::PH_ZERO: begin
        if (char_in == ChLowX || char_in == ChUpX) begin
          step_st.radix_sel  = ilp_pkg::RX_HEX;
          step_st.seen_digit = 1'b0;
          step_st.phase      = ilp_pkg::PH_DIGITS;
        end else if (char_in == ChLowB || char_in == ChUpB) begin
          step_st.radix_sel  = ilp_pkg::RX_BIN;
          step_st.seen_digit = 1'b0;
          step_st.phase      = ilp_pkg::PH_DIGITS;
        end else if (char_in == ChLowO || char_in == ChUpO) begin
          step_st.radix_sel  = ilp_pkg::RX_OCT;
          step_st.seen_digit = 1'b0;
          step_st.phase      = ilp_pkg::PH_DIGITS;
        end else begin
          step_st = take_st;
        end
      end
      ilp_pkg::PH_DIGITS: step_st = take_st;
      default:            step_st.phase = ilp_pkg::PH_ERROR;
    endcase
  end

  always_comb begin
    result.valid_res = 1'b0;
    result.value     = '0;
    if (step_st.phase != ilp_pkg::PH_ERROR && step_st.seen_digit) begin
      result.valid_res = 1'b1;
      result.value     = step_st.negative ? -$signed(step_st.magnitude)
                                          : $signed(step_st.magnitude);
    end
    state_nxt = last_in ? ilp_pkg::StateReset : step_st;
  end

endmodule

// File: rtl/integer_literal_parser.sv
`timescale 1ns / 1ps
// Top level of the streaming integer literal parser.
// Depends on ilp_pkg, the channel interfaces in ilp_if.sv and ilp_step.
//
// Takes a token one character per word, the last character flagged, and for
// each token gives one word: a valid flag and the signed 64-bit value (zero
// when the token is malformed or out of range). One character is accepted
// every cycle unless a token's last character waits for the result slot; the
// result of a token is registered (input register, then result register). The
// rate is set by the combinational step: a multiply by the radix, a digit add
// and a range compare on the 64-bit magnitude. Characters keep flowing while a
// result waits, until a second token end must wait for the result slot.
module integer_literal_parser (
  input  logic         clk,
  input  logic         rst_n,
  ilp_in_if.sink       in_s,
  ilp_out_if.source    out_s
);

  logic                            in_valid_r;
  logic [ilp_pkg::CharWidth-1:0]   in_char_r;
  logic                            in_last_r;
  ilp_pkg::state_t                 state_r;
  ilp_pkg::state_t                 state_nxt;
  ilp_pkg::result_t                res_nxt;
  ilp_pkg::result_t                res_r;
  logic                            out_valid_r;
  logic                            out_free;
  logic                            step_en;

  ilp_step u_step (
    .state_cur (state_r),
    .char_in   (in_char_r),
    .last_in   (in_last_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  assign out_free   = !out_valid_r || out_s.ready;
  assign step_en    = in_valid_r && (!in_last_r || out_free);
  assign in_s.ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      in_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.ready && in_s.valid) begin
      in_char_r <= in_s.character;
      in_last_r <= in_s.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilp_pkg::StateReset;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && in_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_s.valid     = out_valid_r;
  assign out_s.valid_res = res_r.valid_res;
  assign out_s.value     = res_r.value;

endmodule

// File: test/integer_literal_parser_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_literal_parser: directed literals, then
// random tokens under several idling patterns, each result checked in order.
// Depends on ilp_pkg, the channel interfaces in ilp_if.sv and the RTL top.
module integer_literal_parser_test;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PhaseChars   = 268;
  localparam int unsigned DrainCycles  = 10;

  typedef logic [ilp_pkg::CharWidth-1:0] token_t[$];

  logic clk;
  logic rst_n;

  ilp_in_if  in_ch ();
  ilp_out_if out_ch ();

  integer_literal_parser i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  // Parser state as the block should hold it, and the results it owes.
  ilp_pkg::state_t  parse_st;
  ilp_pkg::result_t expected_results[$];
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      chars_sent;
  int unsigned      fail_count;
  int unsigned      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [ilp_pkg::ValueWidth-1:0] radix_weight(input ilp_pkg::radix_t rx);
    case (rx)
      ilp_pkg::RX_HEX: return 64'd16;
      ilp_pkg::RX_OCT: return 64'd8;
      ilp_pkg::RX_BIN: return 64'd2;
      default:         return 64'd10;
    endcase
  endfunction

  function automatic void digit_accumulate(input logic [ilp_pkg::CharWidth-1:0] c);
    logic [ilp_pkg::ValueWidth-1:0] base;
    logic [ilp_pkg::ValueWidth-1:0] limit;
    logic [ilp_pkg::ValueWidth-1:0] d;
    bit                             char_ok;
    base    = radix_weight(parse_st.radix_sel);
    limit   = parse_st.negative ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    char_ok = 1'b1;
    d       = '0;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (parse_st.radix_sel == ilp_pkg::RX_HEX && c >= "a" && c <= "f") begin
      d = c - "a" + 10;
    end else if (parse_st.radix_sel == ilp_pkg::RX_HEX && c >= "A" && c <= "F") begin
      d = c - "A" + 10;
    end else begin
      char_ok = 1'b0;
    end
    if (char_ok && d >= base) char_ok = 1'b0;
    if (!char_ok) begin
      parse_st.phase = ilp_pkg::PH_ERROR;
    end else begin
      parse_st.seen_digit = 1'b1;
      // The magnitude must stay within the range of the sign seen so far.
      if (parse_st.magnitude > (limit - d) / base) begin
        parse_st.phase = ilp_pkg::PH_ERROR;
      end else begin
        parse_st.magnitude = parse_st.magnitude * base + d;
        parse_st.phase     = ilp_pkg::PH_DIGITS;
      end
    end
  endfunction

  function automatic void predict_char(input logic [ilp_pkg::CharWidth-1:0] c,
                                       input bit last_c);
    ilp_pkg::result_t res;
    case (parse_st.phase)
      ilp_pkg::PH_START, ilp_pkg::PH_SIGN: begin
        if (parse_st.phase == ilp_pkg::PH_START && (c == "+" || c == "-")) begin
          parse_st.negative = (c == "-");
          parse_st.phase    = ilp_pkg::PH_SIGN;
        end else if (c == "0" && !last_c) begin
          // A leading zero may still turn out to open a radix prefix.
          parse_st.phase      = ilp_pkg::PH_ZERO;
          parse_st.seen_digit = 1'b1;
          parse_st.magnitude  = '0;
        end else begin
          digit_accumulate(c);
        end
      end
      ilp_pkg::PH_ZERO: begin
        if (c == "x" || c == "X") begin
          parse_st.radix_sel  = ilp_pkg::RX_HEX;
          parse_st.seen_digit = 1'b0;
          parse_st.phase      = ilp_pkg::PH_DIGITS;
        end else if (c == "b" || c == "B") begin
          parse_st.radix_sel  = ilp_pkg::RX_BIN;
          parse_st.seen_digit = 1'b0;
          parse_st.phase      = ilp_pkg::PH_DIGITS;
        end else if (c == "o" || c == "O") begin
          parse_st.radix_sel  = ilp_pkg::RX_OCT;
          parse_st.seen_digit = 1'b0;
          parse_st.phase      = ilp_pkg::PH_DIGITS;
        end else begin
          digit_accumulate(c);
        end
      end
      ilp_pkg::PH_DIGITS: digit_accumulate(c);
      default:            parse_st.phase = ilp_pkg::PH_ERROR;
    endcase
    if (last_c) begin
      res.valid_res = (parse_st.phase != ilp_pkg::PH_ERROR) && parse_st.seen_digit;
      if (res.valid_res) begin
        res.value = parse_st.negative ? -parse_st.magnitude : parse_st.magnitude;
      end else begin
        res.value = '0;
      end
      expected_results.push_back(res);
      parse_st = ilp_pkg::StateReset;
    end
  endfunction

  task automatic send_char(input logic [ilp_pkg::CharWidth-1:0] c, input bit last_c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= c;
    in_ch.last_char <= last_c;
    do @(posedge clk); while (!in_ch.ready);
    predict_char(c, last_c);
    chars_sent++;
  endtask

  task automatic send_token(input token_t tok);
    for (int i = 0; i < tok.size(); i++) begin
      send_char(tok[i], i == tok.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  function automatic token_t random_literal();
    token_t                         tok;
    token_t                         digs;
    ilp_pkg::radix_t                rx;
    logic [ilp_pkg::ValueWidth-1:0] mag;
    logic [ilp_pkg::ValueWidth-1:0] base;
    logic [ilp_pkg::ValueWidth-1:0] d;
    case ($urandom_range(2))
      1:       tok.push_back("+");
      2:       tok.push_back("-");
      default: ;
    endcase
    rx = ilp_pkg::radix_t'($urandom_range(3));
    if (rx != ilp_pkg::RX_DEC) begin
      tok.push_back("0");
      case (rx)
        ilp_pkg::RX_HEX: tok.push_back($urandom_range(1) ? "x" : "X");
        ilp_pkg::RX_OCT: tok.push_back($urandom_range(1) ? "o" : "O");
        default:         tok.push_back($urandom_range(1) ? "b" : "B");
      endcase
    end
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(1, 2)) tok.push_back("0");
    end
    // Bias toward magnitudes around the signed range limits.
    case ($urandom_range(9))
      0, 1, 2, 3: mag = 64'($urandom_range(1000));
      4, 5:       mag = {$urandom, $urandom};
      6:          mag = 64'h7fff_ffff_ffff_ffff + 64'($urandom_range(2));
      7:          mag = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(1));
      8:          mag = {$urandom, $urandom} >> $urandom_range(63);
      default:    mag = '0;
    endcase
    base = radix_weight(rx);
    if (mag == 0) digs.push_back("0");
    while (mag != 0) begin
      d = mag % base;
      if (d < 10) begin
        digs.push_front(ilp_pkg::CharWidth'("0" + d));
      end else begin
        digs.push_front(ilp_pkg::CharWidth'(($urandom_range(1) ? "a" : "A") + d - 10));
      end
      mag = mag / base;
    end
    if ($urandom_range(15) == 0) begin
      digs.push_back(ilp_pkg::CharWidth'("0" + $urandom_range(1)));
    end
    return {tok, digs};
  endfunction

  task automatic run_random_phase(input int unsigned budget);
    token_t      tok;
    int unsigned stop_at;
    int unsigned pos;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) begin
      case ($urandom_range(19))
        0, 1, 2: begin
          // A literal with one byte spoiled or a stray sign inserted.
          tok = random_literal();
          pos = $urandom_range(tok.size() - 1);
          if ($urandom_range(1)) tok[pos] = ilp_pkg::CharWidth'($urandom_range(255));
          else tok.insert(pos, $urandom_range(1) ? "-" : "+");
        end
        3, 4: begin
          tok.delete();
          repeat ($urandom_range(1, 6)) begin
            tok.push_back(ilp_pkg::CharWidth'($urandom_range(255)));
          end
        end
        default: tok = random_literal();
      endcase
      send_token(tok);
    end
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_text("+");
    send_text("-");
    send_text("0x");
    send_text("0B");
    send_text("-0o");
    send_text("0");
    send_text("-0");
    send_text("+7");
    send_text("0X1F");
    send_text("0xaBcD");
    send_text("0b101");
    send_text("0O17");
    send_text("007");
    send_text("00x1");
    send_text("12a3");
    send_text("+-1");
    send_text("0b2");
    send_text("0o8");
    send_text("0xg1");
    send_text("9223372036854775807");
    send_text("9223372036854775808");
    send_text("-9223372036854775808");
    send_text("-9223372036854775809");
    send_text("0x7FFFFFFFFFFFFFFF");
    send_text("-0x8000000000000000");
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
  endtask

  task automatic test_random_no_idling();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_phase(PhaseChars);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct  = 70;
    recv_stall_pct = 0;
    run_random_phase(PhaseChars);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    run_random_phase(PhaseChars);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    run_random_phase(PhaseChars);
  endtask

  // Result side: random back-pressure and in-order comparison of each word.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no token pending: valid_res %0d, value %0d",
                 out_ch.valid_res, $signed(out_ch.value));
          fail_count++;
        end else begin
          ilp_pkg::result_t exp_res;
          exp_res = expected_results.pop_front();
          if (out_ch.valid_res !== exp_res.valid_res) begin
            $error("valid_res: expected %0d, got %0d", exp_res.valid_res, out_ch.valid_res);
            fail_count++;
          end
          if (out_ch.value !== exp_res.value) begin
            $error("value: expected %0d, got %0d",
                   $signed(exp_res.value), $signed(out_ch.value));
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL integer_literal_parser");
      $finish;
    end
  end

  initial begin
    parse_st        = ilp_pkg::StateReset;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    chars_sent      = 0;
    fail_count      = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.character <= '0;
    in_ch.last_char <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_no_idling();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS integer_literal_parser");
    end else begin
      $display("FAIL integer_literal_parser");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ilp_pkg.sv
rtl/ilp_if.sv
rtl/ilp_step.sv
rtl/integer_literal_parser.sv
test/integer_literal_parser_test.sv
